### src/fbd_pkg.sv
// Shared types, codes and constants of the dirty-rectangle pixel store.
package fbd_pkg;

  // Default store geometry
  localparam int unsigned MaxWidthDef  = 512;
  localparam int unsigned MaxHeightDef = 256;

  // Field and coordinate widths
  localparam int unsigned CmdW   = 3;
  localparam int unsigned PosXW  = 9;
  localparam int unsigned PosYW  = 8;
  localparam int unsigned RectWW = 10;
  localparam int unsigned RectHW = 9;
  localparam int unsigned ColorW = 8;
  localparam int unsigned ColW   = 10;  // column bound, as screen_width
  localparam int unsigned RowW   = 9;   // row bound, as screen_height
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 10;

  // Register values after reset
  localparam logic [ColW-1:0] ScreenWidthRst  = 10'd320;
  localparam logic [RowW-1:0] ScreenHeightRst = 9'd200;

  typedef enum logic [CmdW-1:0] {
    CMD_PUT   = 3'd0,
    CMD_GET   = 3'd1,
    CMD_FILL  = 3'd2,
    CMD_MARK  = 3'd3,
    CMD_CLEAR = 3'd4,
    CMD_FLUSH = 3'd5
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_FILL
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [PosXW-1:0]  pos_x;
    logic [PosYW-1:0]  pos_y;
    logic [RectWW-1:0] rect_w;
    logic [RectHW-1:0] rect_h;
    logic [ColorW-1:0] color;
  } cmd_t;

  typedef struct packed {
    logic [ColorW-1:0] pixel_value;
    logic              box_valid;
    logic [PosXW-1:0]  box_left;
    logic [PosYW-1:0]  box_top;
    logic [ColW-1:0]   box_right;
    logic [RowW-1:0]   box_bottom;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_t;

endpackage

### src/fbd_if.sv
// Handshake channel interfaces for commands, results and register writes.
interface fbd_cmd_if;
  import fbd_pkg::*;
  logic valid;
  logic ready;
  cmd_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface fbd_res_if;
  import fbd_pkg::*;
  logic valid;
  logic ready;
  res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface fbd_cfg_if;
  import fbd_pkg::*;
  logic valid;
  logic ready;
  cfg_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/fbd_mem.sv
// Single-port pixel memory with registered read data.
module fbd_mem #(
  parameter int unsigned Depth = 131072,
  parameter int unsigned AddrW = 17
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          addr_i,
  input  logic [fbd_pkg::ColorW-1:0] wdata_i,
  output logic [fbd_pkg::ColorW-1:0] rdata_o
);
  import fbd_pkg::*;

  logic [ColorW-1:0] mem_q [Depth];

  // Write takes the port; a read returns its data in the next cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

### src/fbd_out_fifo.sv
// Two-entry result queue that parts the command side from the result side.
module fbd_out_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fbd_pkg::res_t push_data_i,
  output logic          can_push_o,
  output logic          valid_o,
  input  logic          ready_i,
  output fbd_pkg::res_t data_o
);
  import fbd_pkg::*;

  res_t       ent_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop        = valid_o && ready_i;
  assign valid_o    = (cnt_q != 2'd0);
  assign data_o     = ent_q[rptr_q];
  assign can_push_o = (cnt_q != 2'd2) || pop;

  // Advance pointers and occupancy
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop) begin
      rptr_d = ~rptr_q;
    end
    unique case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold the entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= push_data_i;
    end
  end

endmodule

### src/fbd_ctrl.sv
// Command sequencer: clipping, dirty box, fill walker and start-up clearing.
module fbd_ctrl #(
  parameter int unsigned MaxWidth  = 512,
  parameter int unsigned MaxHeight = 256,
  parameter int unsigned Depth     = 131072,
  parameter int unsigned AddrW     = 17
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  fbd_pkg::cmd_t              cmd_i,
  output logic                       cmd_ready_o,
  input  logic                       cfg_valid_i,
  input  fbd_pkg::cfg_t              cfg_i,
  output logic                       cfg_ready_o,
  output logic                       push_o,
  output fbd_pkg::res_t              push_data_o,
  input  logic                       can_push_i,
  output logic                       mem_we_o,
  output logic                       mem_re_o,
  output logic [AddrW-1:0]           mem_addr_o,
  output logic [fbd_pkg::ColorW-1:0] mem_wdata_o,
  input  logic [fbd_pkg::ColorW-1:0] mem_rdata_i
);
  import fbd_pkg::*;

  state_e state_q, state_d;

  // Configuration registers
  logic [ColW-1:0] scr_w_q;
  logic [RowW-1:0] scr_h_q;

  // Dirty box
  logic             dflag_q, dflag_d;
  logic [PosXW-1:0] dleft_q, dleft_d;
  logic [PosYW-1:0] dtop_q, dtop_d;
  logic [ColW-1:0]  dright_q, dright_d;
  logic [RowW-1:0]  dbot_q, dbot_d;

  // Fill walker and clearing counter
  logic [ColW-1:0]   wx_q, wl_q, wr_q;
  logic [RowW-1:0]   wy_q, wb_q;
  logic [ColorW-1:0] wcol_q;
  logic [AddrW-1:0]  clr_addr_q;

  logic              accept;
  logic [ColW-1:0]   sw;
  logic [RowW-1:0]   sh;
  logic              pix_in;
  logic              rect_ok;
  logic              scr_ok;
  logic [ColW:0]     r_full;
  logic [RowW:0]     b_full;
  logic [ColW-1:0]   r_clip;
  logic [RowW-1:0]   b_clip;
  logic [AddrW-1:0]  pix_addr;
  logic [AddrW-1:0]  walk_addr;
  logic [ColW-1:0]   wx_inc;
  logic [RowW-1:0]   wy_inc;
  logic              walk_row_end;
  logic              walk_last;
  logic              clr_end;
  logic              fill_start;
  logic              clear_start;

  // Widening request
  logic             wid_en;
  logic [PosXW-1:0] wid_l;
  logic [PosYW-1:0] wid_t;
  logic [ColW-1:0]  wid_r;
  logic [RowW-1:0]  wid_b;

  assign accept      = cmd_valid_i && cmd_ready_o;
  assign cfg_ready_o = 1'b1;

  // Clip to the effective screen
  always_comb begin
    sw = (32'(scr_w_q) > 32'(MaxWidth)) ? ColW'(MaxWidth) : scr_w_q;
    sh = (32'(scr_h_q) > 32'(MaxHeight)) ? RowW'(MaxHeight) : scr_h_q;
    pix_in  = ({1'b0, cmd_i.pos_x} < sw) && ({1'b0, cmd_i.pos_y} < sh);
    rect_ok = pix_in && (cmd_i.rect_w != '0) && (cmd_i.rect_h != '0);
    scr_ok  = (sw != '0) && (sh != '0);
    r_full  = (ColW + 1)'(cmd_i.pos_x) + (ColW + 1)'(cmd_i.rect_w);
    b_full  = (RowW + 1)'(cmd_i.pos_y) + (RowW + 1)'(cmd_i.rect_h);
    r_clip  = (r_full > (ColW + 1)'(sw)) ? sw : r_full[ColW-1:0];
    b_clip  = (b_full > (RowW + 1)'(sh)) ? sh : b_full[RowW-1:0];
    pix_addr  = AddrW'(cmd_i.pos_y) * AddrW'(MaxWidth) + AddrW'(cmd_i.pos_x);
    walk_addr = AddrW'(wy_q) * AddrW'(MaxWidth) + AddrW'(wx_q);
    wx_inc       = wx_q + ColW'(1);
    wy_inc       = wy_q + RowW'(1);
    walk_row_end = (wx_inc == wr_q);
    walk_last    = walk_row_end && (wy_inc == wb_q);
    clr_end      = (clr_addr_q == AddrW'(Depth - 1));
  end

  // Decode the accepted item
  always_comb begin
    fill_start  = 1'b0;
    clear_start = 1'b0;
    wid_en = 1'b0;
    wid_l  = cmd_i.pos_x;
    wid_t  = cmd_i.pos_y;
    wid_r  = r_clip;
    wid_b  = b_clip;
    unique case (cmd_i.command)
      CMD_PUT: begin
        wid_en = pix_in;
        wid_r  = ColW'(cmd_i.pos_x) + ColW'(1);
        wid_b  = RowW'(cmd_i.pos_y) + RowW'(1);
      end
      CMD_FILL: begin
        wid_en     = rect_ok;
        fill_start = rect_ok;
      end
      CMD_MARK: begin
        wid_en = rect_ok;
      end
      CMD_CLEAR: begin
        wid_en      = scr_ok;
        clear_start = scr_ok;
        wid_l = '0;
        wid_t = '0;
        wid_r = sw;
        wid_b = sh;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (clr_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if ((cmd_i.command == CMD_GET) && pix_in) begin
            state_d = ST_READ;
          end else if (fill_start || clear_start) begin
            state_d = ST_FILL;
          end
        end
      end
      ST_READ: state_d = ST_IDLE;
      ST_FILL: begin
        if (walk_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Outputs: handshake, memory port and result push
  always_comb begin
    cmd_ready_o = (state_q == ST_IDLE) && can_push_i;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_addr_o  = pix_addr;
    mem_wdata_o = cmd_i.color;
    push_o      = 1'b0;
    push_data_o = '0;
    unique case (state_q)
      ST_INIT: begin
        mem_we_o    = 1'b1;
        mem_addr_o  = clr_addr_q;
        mem_wdata_o = '0;
      end
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i.command == CMD_GET && pix_in) begin
            mem_re_o = 1'b1;
          end else begin
            push_o   = 1'b1;
            mem_we_o = (cmd_i.command == CMD_PUT) && pix_in;
            if ((cmd_i.command == CMD_FLUSH) && dflag_q) begin
              push_data_o.box_valid  = 1'b1;
              push_data_o.box_left   = dleft_q;
              push_data_o.box_top    = dtop_q;
              push_data_o.box_right  = dright_q;
              push_data_o.box_bottom = dbot_q;
            end
          end
        end
      end
      ST_READ: begin
        push_o = 1'b1;
        push_data_o.pixel_value = mem_rdata_i;
      end
      ST_FILL: begin
        mem_we_o    = 1'b1;
        mem_addr_o  = walk_addr;
        mem_wdata_o = wcol_q;
      end
      default: ;
    endcase
  end

  // Widen or load the dirty box; a flush drops it
  always_comb begin
    dflag_d  = dflag_q;
    dleft_d  = dleft_q;
    dtop_d   = dtop_q;
    dright_d = dright_q;
    dbot_d   = dbot_q;
    if (accept && wid_en) begin
      dflag_d = 1'b1;
      if (!dflag_q) begin
        dleft_d  = wid_l;
        dtop_d   = wid_t;
        dright_d = wid_r;
        dbot_d   = wid_b;
      end else begin
        if (wid_l < dleft_q) dleft_d = wid_l;
        if (wid_t < dtop_q) dtop_d = wid_t;
        if (wid_r > dright_q) dright_d = wid_r;
        if (wid_b > dbot_q) dbot_d = wid_b;
      end
    end else if (accept && (cmd_i.command == CMD_FLUSH)) begin
      dflag_d = 1'b0;
    end
  end

  // Control state, box and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      clr_addr_q <= '0;
      scr_w_q    <= ScreenWidthRst;
      scr_h_q    <= ScreenHeightRst;
      dflag_q    <= 1'b0;
      dleft_q    <= '0;
      dtop_q     <= '0;
      dright_q   <= '0;
      dbot_q     <= '0;
    end else begin
      state_q  <= state_d;
      dflag_q  <= dflag_d;
      dleft_q  <= dleft_d;
      dtop_q   <= dtop_d;
      dright_q <= dright_d;
      dbot_q   <= dbot_d;
      if ((state_q == ST_INIT) && !clr_end) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_i.index)
          REG_SCREEN_WIDTH:  scr_w_q <= cfg_i.data[ColW-1:0];
          REG_SCREEN_HEIGHT: scr_h_q <= cfg_i.data[RowW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Load the walker on a fill or clear, then step column by column
  always_ff @(posedge clk_i) begin
    if (accept && fill_start) begin
      wx_q   <= ColW'(cmd_i.pos_x);
      wl_q   <= ColW'(cmd_i.pos_x);
      wy_q   <= RowW'(cmd_i.pos_y);
      wr_q   <= r_clip;
      wb_q   <= b_clip;
      wcol_q <= cmd_i.color;
    end else if (accept && clear_start) begin
      wx_q   <= '0;
      wl_q   <= '0;
      wy_q   <= '0;
      wr_q   <= sw;
      wb_q   <= sh;
      wcol_q <= cmd_i.color;
    end else if (state_q == ST_FILL) begin
      if (walk_row_end) begin
        wx_q <= wl_q;
        wy_q <= wy_inc;
      end else begin
        wx_q <= wx_inc;
      end
    end
  end

endmodule

### src/framebuffer_fill_with_dirty_rect_top.sv
// Top level of the dirty-rectangle tracking pixel store.
//
//  channel  dir  modport  carries
//  cmd_i    in   sink     command, pos_x, pos_y, rect_w, rect_h, color
//  res_o    out  source   pixel_value, box_valid, box_left/top/right/bottom
//  cfg_i    in   sink     index (0 screen_width, 1 screen_height), data
//
// Put, mark, flush, off-screen get and unused codes push their result as they
// are taken; an on-screen get first reads the pixel memory (ST_READ).
// Fill and clear push their result when taken and then write the clipped area
// pixel by pixel (ST_FILL) through the single write port of the pixel memory.
// After reset a clearing pass writes zero to all MaxWidth*MaxHeight entries,
// one a cycle; no item is taken meanwhile.
// Results queue in two entries, so items keep flowing while one result waits.
module framebuffer_fill_with_dirty_rect_top #(
  parameter int unsigned MaxWidth  = fbd_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = fbd_pkg::MaxHeightDef
) (
  input logic clk_i,
  input logic rst_ni,
  fbd_cmd_if.sink   cmd_i,
  fbd_res_if.source res_o,
  fbd_cfg_if.sink   cfg_i
);
  import fbd_pkg::*;

  localparam int unsigned Depth = MaxWidth * MaxHeight;
  localparam int unsigned AddrW = $clog2(Depth);

  logic              push;
  res_t              push_data;
  logic              can_push;
  logic              mem_we;
  logic              mem_re;
  logic [AddrW-1:0]  mem_addr;
  logic [ColorW-1:0] mem_wdata;
  logic [ColorW-1:0] mem_rdata;
  logic              cmd_ready;
  logic              cfg_ready;
  logic              res_valid;
  res_t              res_data;

  assign cmd_i.ready   = cmd_ready;
  assign cfg_i.ready   = cfg_ready;
  assign res_o.valid   = res_valid;
  assign res_o.payload = res_data;

  fbd_ctrl #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight),
    .Depth     (Depth),
    .AddrW     (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_i       (cmd_i.payload),
    .cmd_ready_o (cmd_ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_i       (cfg_i.payload),
    .cfg_ready_o (cfg_ready),
    .push_o      (push),
    .push_data_o (push_data),
    .can_push_i  (can_push),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  fbd_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  fbd_out_fifo u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .can_push_o  (can_push),
    .valid_o     (res_valid),
    .ready_i     (res_o.ready),
    .data_o      (res_data)
  );

endmodule

### src/fbd_checker.sv
// Port-level checks of the pixel store and the bind that attaches them.
module fbd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          res_valid_i,
  input logic          res_ready_i,
  input fbd_pkg::res_t res_i
);
  import fbd_pkg::*;

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_i))
    else $error("result changed while stalled");

  // A reported box is never empty
  a_box_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_i.box_valid |->
      ({1'b0, res_i.box_left} < res_i.box_right) &&
      ({1'b0, res_i.box_top} < res_i.box_bottom))
    else $error("flush reported an empty box");

  // Without a valid box all box fields are zero
  a_box_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_i.box_valid |->
      (res_i.box_left == '0) && (res_i.box_top == '0) &&
      (res_i.box_right == '0) && (res_i.box_bottom == '0))
    else $error("box fields set without a valid box");

  // A read pixel and a box never come in one result
  a_pix_or_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_i.pixel_value != '0) |-> !res_i.box_valid)
    else $error("pixel value and box in one result");

endmodule

bind framebuffer_fill_with_dirty_rect_top fbd_checker u_fbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_i       (res_o.payload)
);
